// ===== design/ptla_pkg.sv =====
// Shared types, constants and helpers of the peer address table.
package ptla_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Result field widths
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int REMOVED_W = 7;
    localparam int TIME_W    = 32;

    localparam int SLOT_WIDE_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int COUNT_WIDE_W = (CNT_W > REMOVED_W) ? CNT_W : REMOVED_W;

    localparam logic [TIME_W-1:0] IDLE_LIMIT_RESET = 32'd30000;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TIME_W-1:0] time_t;

    // Item mode
    typedef enum logic {
        MODE_TOUCH = 1'b0,
        MODE_TICK  = 1'b1
    } mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_FREE  = 2'd1,
        ST_EVICT = 2'd2,
        ST_SWEEP = 2'd3
    } status_t;

    // Lookup key of one peer
    typedef struct packed {
        logic        family_v6;
        logic [15:0] port_number;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } ptla_key_t;

    // Control from the sequencer to the entry store
    typedef struct packed {
        logic rd_en;
        idx_t rd_idx;
        logic wr_key;
        logic wr_time;
        logic set_valid;
        logic clr_valid;
        idx_t wr_idx;
    } ptla_mem_ctl_t;

    // Slot index as reported, masked or zero-extended to the field width
    function automatic logic [SLOT_W-1:0] to_slot(input idx_t i);
        logic [SLOT_WIDE_W-1:0] w;
        w = SLOT_WIDE_W'(i);
        return w[SLOT_W-1:0];
    endfunction

    // Removal count as reported, masked or zero-extended to the field width
    function automatic logic [REMOVED_W-1:0] to_removed(input cnt_t c);
        logic [COUNT_WIDE_W-1:0] w;
        w = COUNT_WIDE_W'(c);
        return w[REMOVED_W-1:0];
    endfunction

endpackage

// ===== design/ptla_store.sv =====
// Entry store: key and last-seen memories with registered reads, plus valid bits.
module ptla_store
    import ptla_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  ptla_mem_ctl_t mem_ctl,
    input  ptla_key_t     wr_key_data,
    input  time_t         wr_time_data,
    output ptla_key_t     rd_key,
    output time_t         rd_time,
    output logic          rd_valid
);

    ptla_key_t key_mem  [TABLE_ENTRIES];
    time_t     time_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    ptla_key_t                rd_key_reg;
    time_t                    rd_time_reg;
    logic                     rd_valid_reg;

    // Write the key memory on insert
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_key) begin
            key_mem[mem_ctl.wr_idx] <= wr_key_data;
        end
    end

    // Write the last-seen memory on every touch
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_time) begin
            time_mem[mem_ctl.wr_idx] <= wr_time_data;
        end
    end

    // Registered read port, valid bit sampled alongside
    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            rd_key_reg   <= key_mem[mem_ctl.rd_idx];
            rd_time_reg  <= time_mem[mem_ctl.rd_idx];
            rd_valid_reg <= valid_reg[mem_ctl.rd_idx];
        end
    end

    // Set on insert, clear on idle removal
    always_comb begin
        valid_next = valid_reg;
        if (mem_ctl.set_valid) begin
            valid_next[mem_ctl.wr_idx] = 1'b1;
        end else if (mem_ctl.clr_valid) begin
            valid_next[mem_ctl.wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_time  = rd_time_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== design/ptla_ctrl.sv =====
// Scan sequencer: walks the store once per item, commits a touch, issues the result.
module ptla_ctrl
    import ptla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic                 s_family_v6,
    input  logic [63:0]          s_address_high,
    input  logic [63:0]          s_address_low,
    input  logic [15:0]          s_port_number,
    input  logic [TIME_W-1:0]    s_now_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [SLOT_W-1:0]    m_slot,
    output logic [SLOT_W-1:0]    m_evicted_slot,
    output logic [REMOVED_W-1:0] m_removed_count,
    input  logic                 cfg_wr_en,
    input  logic [TIME_W-1:0]    cfg_wr_data,
    output ptla_mem_ctl_t        mem_ctl,
    output ptla_key_t            wr_key_data,
    output time_t                wr_time_data,
    input  ptla_key_t            rd_key,
    input  time_t                rd_time,
    input  logic                 rd_valid
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t    state_reg, state_next;
    mode_t     mode_reg;
    ptla_key_t key_reg;
    time_t     now_reg;
    time_t     idle_limit_reg, idle_limit_next;

    idx_t rd_idx_reg, rd_idx_next;
    logic cmp_vld_reg, cmp_vld_next;
    idx_t cmp_idx_reg, cmp_idx_next;

    logic  hit_reg, hit_next;
    idx_t  hit_idx_reg, hit_idx_next;
    logic  free_reg, free_next;
    idx_t  free_idx_reg, free_idx_next;
    logic  old_reg, old_next;
    time_t old_age_reg, old_age_next;
    idx_t  old_idx_reg, old_idx_next;
    cnt_t  removed_reg, removed_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [SLOT_W-1:0]    m_slot_reg, m_slot_next;
    logic [SLOT_W-1:0]    m_evicted_reg, m_evicted_next;
    logic [REMOVED_W-1:0] m_removed_reg, m_removed_next;

    logic  accept;
    logic  out_free;
    time_t age;
    logic  key_eq;
    logic  live;
    logic  expired;
    idx_t  commit_idx;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Compare stage: data of entry cmp_idx_reg is on the read port
    assign age     = now_reg - rd_time;
    assign key_eq  = (rd_key == key_reg);
    assign live    = cmp_vld_reg && rd_valid;
    assign expired = live && (mode_reg == MODE_TICK) && (age >= idle_limit_reg);

    // Pick the slot the touch lands on
    always_comb begin
        if (hit_reg) begin
            commit_idx = hit_idx_reg;
        end else if (free_reg) begin
            commit_idx = free_idx_reg;
        end else begin
            commit_idx = old_idx_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        idle_limit_next = idle_limit_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_vld_next    = (state_reg == S_SCAN);
        cmp_idx_next    = rd_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        old_next        = old_reg;
        old_age_next    = old_age_reg;
        old_idx_next    = old_idx_reg;
        removed_next    = removed_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_evicted_next  = m_evicted_reg;
        m_removed_next  = m_removed_reg;
        mem_ctl         = '0;
        mem_ctl.rd_idx  = rd_idx_reg;
        mem_ctl.wr_idx  = cmp_idx_reg;

        // Take configuration writes at any time
        if (cfg_wr_en) begin
            idle_limit_next = cfg_wr_data;
        end

        // Accumulate hit, first free slot, oldest entry and removals
        if (live && (mode_reg == MODE_TOUCH)) begin
            if (!hit_reg && key_eq) begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
            end
            if (!old_reg || (age > old_age_reg)) begin
                old_next     = 1'b1;
                old_age_next = age;
                old_idx_next = cmp_idx_reg;
            end
        end else if (cmp_vld_reg && !rd_valid && (mode_reg == MODE_TOUCH) && !free_reg) begin
            free_next     = 1'b1;
            free_idx_next = cmp_idx_reg;
        end
        if (expired) begin
            mem_ctl.clr_valid = 1'b1;
            removed_next      = removed_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    rd_idx_next  = '0;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    old_next     = 1'b0;
                    removed_next = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue one read per cycle
                mem_ctl.rd_en = 1'b1;
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = S_WAIT;
                end else begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            S_WAIT: begin
                // Last entry is compared this cycle
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // Commit a touch and load the output register together
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (mode_reg == MODE_TICK) begin
                        m_status_next  = ST_SWEEP;
                        m_slot_next    = '0;
                        m_evicted_next = '0;
                        m_removed_next = to_removed(removed_reg);
                    end else begin
                        mem_ctl.wr_idx    = commit_idx;
                        mem_ctl.wr_time   = 1'b1;
                        mem_ctl.wr_key    = !hit_reg;
                        mem_ctl.set_valid = !hit_reg;
                        m_slot_next       = to_slot(commit_idx);
                        m_removed_next    = '0;
                        if (hit_reg) begin
                            m_status_next  = ST_HIT;
                            m_evicted_next = '0;
                        end else if (free_reg) begin
                            m_status_next  = ST_FREE;
                            m_evicted_next = '0;
                        end else begin
                            m_status_next  = ST_EVICT;
                            m_evicted_next = to_slot(old_idx_reg);
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idle_limit_reg <= IDLE_LIMIT_RESET;
            cmp_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idle_limit_reg <= idle_limit_next;
            cmp_vld_reg    <= cmp_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Scan and result registers
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        old_reg       <= old_next;
        old_age_reg   <= old_age_next;
        old_idx_reg   <= old_idx_next;
        removed_reg   <= removed_next;
        m_status_reg  <= m_status_next;
        m_slot_reg    <= m_slot_next;
        m_evicted_reg <= m_evicted_next;
        m_removed_reg <= m_removed_next;
    end

    // Hold the accepted beat for the whole scan
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg             <= mode_t'(s_mode);
            key_reg.family_v6    <= s_family_v6;
            key_reg.port_number  <= s_port_number;
            key_reg.address_high <= s_address_high;
            key_reg.address_low  <= s_address_low;
            now_reg              <= s_now_time;
        end
    end

    assign wr_key_data     = key_reg;
    assign wr_time_data    = now_reg;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_slot          = m_slot_reg;
    assign m_evicted_slot  = m_evicted_reg;
    assign m_removed_count = m_removed_reg;

endmodule

// ===== design/peer_table_lru_evict_aging.sv =====
// A beat accepted in S_IDLE passes through S_SCAN, S_WAIT and S_FINISH, then its result
// shows on m_valid. Items are taken one at a time, paced by the one read port of the entry
// memories, which the scan walks one entry per cycle.
// A result waiting on m_ready stalls only the commit of the next item, not its scan.
// Reset (aresetn low, synchronous) clears all valid bits at once and sets idle_limit to 30000;
// no clearing pass is needed, so the first beat is taken the cycle after reset.
module peer_table_lru_evict_aging
    import ptla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic                 s_family_v6,
    input  logic [63:0]          s_address_high,
    input  logic [63:0]          s_address_low,
    input  logic [15:0]          s_port_number,
    input  logic [TIME_W-1:0]    s_now_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [SLOT_W-1:0]    m_slot,
    output logic [SLOT_W-1:0]    m_evicted_slot,
    output logic [REMOVED_W-1:0] m_removed_count,
    input  logic                 cfg_wr_en,
    input  logic [TIME_W-1:0]    cfg_wr_data
);

    ptla_mem_ctl_t mem_ctl;
    ptla_key_t     wr_key_data;
    time_t         wr_time_data;
    ptla_key_t     rd_key;
    time_t         rd_time;
    logic          rd_valid;

    // Sequencer
    ptla_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_family_v6     (s_family_v6),
        .s_address_high  (s_address_high),
        .s_address_low   (s_address_low),
        .s_port_number   (s_port_number),
        .s_now_time      (s_now_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_evicted_slot  (m_evicted_slot),
        .m_removed_count (m_removed_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mem_ctl         (mem_ctl),
        .wr_key_data     (wr_key_data),
        .wr_time_data    (wr_time_data),
        .rd_key          (rd_key),
        .rd_time         (rd_time),
        .rd_valid        (rd_valid)
    );

    // Entry memories
    ptla_store u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mem_ctl      (mem_ctl),
        .wr_key_data  (wr_key_data),
        .wr_time_data (wr_time_data),
        .rd_key       (rd_key),
        .rd_time      (rd_time),
        .rd_valid     (rd_valid)
    );

endmodule

// ===== design/ptla_chk.sv =====
// Port-level checker for the peer address table, bound to the top level.
module ptla_chk
    import ptla_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [STATUS_W-1:0]  m_status,
    input logic [SLOT_W-1:0]    m_slot,
    input logic [SLOT_W-1:0]    m_evicted_slot,
    input logic [REMOVED_W-1:0] m_removed_count
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot)
            && $stable(m_evicted_slot) && $stable(m_removed_count))
        else $error("result beat changed while stalled");

    // One item in flight: no second beat right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is being scanned");

    // A sweep reports no slots
    a_sweep_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_SWEEP) |-> (m_slot == '0) && (m_evicted_slot == '0))
        else $error("sweep result carries a slot");

    // Evicted slot only on eviction, and it is the slot reused
    a_evict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == ST_EVICT) && (m_evicted_slot == m_slot))
            || ((m_status != ST_EVICT) && (m_evicted_slot == '0)))
        else $error("evicted slot inconsistent with status");

    // Touches remove nothing
    a_touch_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_SWEEP) |-> (m_removed_count == '0))
        else $error("touch result reports removals");

endmodule

bind peer_table_lru_evict_aging ptla_chk u_ptla_chk (.*);
